// File: hw/rtl/gpio_port_serial_rtc_top_macros.svh
// Assertion macros shared by the GPIO port / serial RTC RTL.
// Define NO_ASSERTIONS to compile them out. Needs aclk and aresetn in scope.
`ifndef GPIO_PORT_SERIAL_RTC_TOP_MACROS_SVH
`define GPIO_PORT_SERIAL_RTC_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GPSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gpsr check failed");
`define GPSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gpsr check failed");
`else
`define GPSR_ASSERT_IMP(lbl, ante, cons)
`define GPSR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/gpsr_pkg.sv
// Types, codes and helper functions for the GPIO port / serial RTC block.
// No dependencies.
package gpsr_pkg;

    localparam int PinCount  = 4;
    localparam int TimeBytes = 7;
    localparam int BcdWidth  = 8 * TimeBytes;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd1;
    localparam logic [1:0] KIND_CTRL = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [2:0] CMD_RESET    = 3'd0;
    localparam logic [2:0] CMD_DATETIME = 3'd2;
    localparam logic [2:0] CMD_CONTROL  = 3'd4;
    localparam logic [2:0] CMD_TIME     = 3'd6;

    localparam logic [3:0] CMD_MAGIC     = 4'h6;
    localparam logic [7:0] CONTROL_RESET = 8'h40;
    localparam logic [7:0] IDLE_BYTE     = 8'hFF;

    localparam logic [0:0] REG_BUG_COMPAT  = 1'b0;
    localparam logic [0:0] REG_RTC_PRESENT = 1'b1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [3:0]          value;
        logic [BcdWidth-1:0] clock_bcd;
    } in_item_t;

    typedef struct packed {
        logic [3:0] visible_data;
        logic [3:0] visible_direction;
        logic       visible_control;
        logic [3:0] pins_now;
    } out_item_t;

    function automatic logic [2:0] data_len(input logic [2:0] code);
        logic [2:0] len;
        case (code)
            CMD_DATETIME: len = 3'd7;
            CMD_CONTROL:  len = 3'd1;
            CMD_TIME:     len = 3'd3;
            default:      len = 3'd0;
        endcase
        return len;
    endfunction

    // BCD-ish hour byte -> (tens*10 + ones) mod 12, back to BCD.
    // floor(x/12) as (x*683)>>13, exact for x <= 165.
    function automatic logic [7:0] hour12(input logic [7:0] h);
        logic [7:0]  bin;
        logic [17:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        logic [3:0]  ones;
        bin  = 8'(h[7:4]) * 8'd10 + 8'(h[3:0]);
        prod = 18'(bin) * 18'd683;
        q    = prod[16:13];
        r    = bin - 8'(q * 8'd12);
        ones = (r >= 8'd10) ? 4'(r - 8'd10) : r[3:0];
        return {3'b000, (r >= 8'd10), ones};
    endfunction

endpackage

// File: hw/rtl/gpsr_rtc.sv
// Three-wire serial RTC behind the port pins: command shifter, control and time bytes.
// Depends on gpsr_pkg and gpio_port_serial_rtc_top_macros.svh.
`include "gpio_port_serial_rtc_top_macros.svh"
module gpsr_rtc
    import gpsr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [3:0]          pins_in,
    input  logic [3:0]          dir_mask,
    input  logic [BcdWidth-1:0] clock_bcd,
    output logic [3:0]          pins_out
);

    localparam int HourIdx = 4;

    logic [7:0] shift_reg, shift_next;
    logic [2:0] bitcnt_reg, bitcnt_next;
    logic [2:0] bytes_left_reg, bytes_left_next;
    logic       active_reg, active_next;
    logic [7:0] cmd_reg, cmd_next;
    logic       sck_prev_reg, sck_prev_next;
    logic       sio_drive_reg, sio_drive_next;
    logic [7:0] control_reg, control_next;
    logic [7:0] time_reg [TimeBytes];
    logic       latch_go;

    logic [3:0] p1, p2;
    logic [7:0] sh;
    logic       rising;
    logic       sio;
    logic [2:0] tidx;
    logic [7:0] out_byte;
    logic [2:0] bl_step;
    logic       cs_low;

    function automatic logic [3:0] drive(input logic [3:0] p, input logic [3:0] dm,
                                         input logic [3:0] level);
        return (p & dm) | (level & ~dm);
    endfunction

    assign tidx    = 3'd7 - bytes_left_reg;
    assign bl_step = (bytes_left_reg <= 3'd1) ? data_len(cmd_reg[6:4])
                                              : bytes_left_reg - 3'd1;

    always_comb begin
        out_byte = IDLE_BYTE;
        if (cmd_reg[6:4] == CMD_CONTROL) begin
            out_byte = control_reg;
        end else if (cmd_reg[6:4] == CMD_DATETIME || cmd_reg[6:4] == CMD_TIME) begin
            if (bytes_left_reg != 3'd0) begin
                out_byte = time_reg[tidx];
            end
        end
    end

    always_comb begin
        shift_next      = shift_reg;
        bitcnt_next     = bitcnt_reg;
        bytes_left_next = bytes_left_reg;
        active_next     = active_reg;
        cmd_next        = cmd_reg;
        sck_prev_next   = sck_prev_reg;
        sio_drive_next  = sio_drive_reg;
        control_next    = control_reg;
        latch_go        = 1'b0;
        sh              = shift_reg;
        sio             = sio_drive_reg;
        p2              = 4'd0;

        p1       = drive(pins_in, dir_mask, pins_in & 4'b0010);
        pins_out = p1;
        cs_low   = !p1[2];
        rising   = !sck_prev_reg && p1[0];

        if (cs_low) begin
            bitcnt_next     = 3'd0;
            bytes_left_next = 3'd0;
            active_next     = 1'b0;
            cmd_next        = 8'd0;
            sck_prev_next   = 1'b1;
            sio_drive_next  = 1'b1;
            pins_out        = drive(p1, dir_mask, 4'b0010);
        end else begin
            if (!cmd_reg[7] || !active_reg) begin
                p2 = drive(p1, dir_mask, 4'b0010);
                if (!p2[0]) begin
                    sh[bitcnt_reg] = p2[1];
                end
                if (active_reg && rising && (sh[bitcnt_reg] ^ p2[1])) begin
                    sh[bitcnt_reg] = 1'b0;
                end
                shift_next = sh;
                if (rising) begin
                    bitcnt_next = bitcnt_reg + 3'd1;
                    if (bitcnt_reg == 3'd7) begin
                        if (!active_reg) begin
                            if (sh[3:0] == CMD_MAGIC) begin
                                cmd_next        = sh;
                                bytes_left_next = data_len(sh[6:4]);
                                active_next     = 1'b1;
                                if (sh[6:4] == CMD_RESET) begin
                                    control_next = 8'd0;
                                end else if (sh[6:4] == CMD_DATETIME ||
                                             sh[6:4] == CMD_TIME) begin
                                    latch_go = 1'b1;
                                end
                            end
                        end else begin
                            if (cmd_reg[6:4] == CMD_CONTROL) begin
                                control_next = sh;
                            end
                            bytes_left_next = bl_step;
                        end
                        shift_next = 8'd0;
                    end
                end
                pins_out = p2;
            end else begin
                if (sck_prev_reg && !p1[0]) begin
                    sio         = out_byte[bitcnt_reg];
                    bitcnt_next = bitcnt_reg + 3'd1;
                    if (bitcnt_reg == 3'd7) begin
                        bytes_left_next = bl_step;
                    end
                end
                sio_drive_next = sio;
                pins_out       = drive(p1, dir_mask, {2'b00, sio, 1'b0});
            end
            sck_prev_next = pins_out[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg      <= 8'd0;
            bitcnt_reg     <= 3'd0;
            bytes_left_reg <= 3'd0;
            active_reg     <= 1'b0;
            cmd_reg        <= 8'd0;
            sck_prev_reg   <= 1'b1;
            sio_drive_reg  <= 1'b1;
            control_reg    <= CONTROL_RESET;
        end else if (step_en) begin
            shift_reg      <= shift_next;
            bitcnt_reg     <= bitcnt_next;
            bytes_left_reg <= bytes_left_next;
            active_reg     <= active_next;
            cmd_reg        <= cmd_next;
            sck_prev_reg   <= sck_prev_next;
            sio_drive_reg  <= sio_drive_next;
            control_reg    <= control_next;
        end
    end

    // year in entry 0, seconds in entry 6; hour in entry 4
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TimeBytes; i++) begin
                time_reg[i] <= 8'd0;
            end
        end else if (step_en && latch_go) begin
            for (int i = 0; i < TimeBytes; i++) begin
                if (i == HourIdx && !control_reg[6]) begin
                    time_reg[i] <= hour12(clock_bcd[8*(TimeBytes-1-i) +: 8]);
                end else begin
                    time_reg[i] <= clock_bcd[8*(TimeBytes-1-i) +: 8];
                end
            end
        end
    end

    `GPSR_ASSERT_IMP(a_idle_no_cmd, !active_reg, cmd_reg == 8'd0)
    `GPSR_ASSERT_IMP(a_cmd_magic, active_reg, cmd_reg[3:0] == CMD_MAGIC)
    `GPSR_ASSERT_NXT(a_cs_abort, step_en && cs_low, bitcnt_reg == 3'd0 && !active_reg)

endmodule

// File: hw/rtl/gpio_port_serial_rtc_top.sv
// An accepted item is held in the input register and its result is registered in the
// output register, from which it can be taken. Throughput: one item per cycle unless
// m_ready stalls the output; the port state update and RTC step are one register pass.
// Reset (aresetn, synchronous, active low): pins, direction, read enable cleared,
// RTC idle with control 0x40, bug_compat 0, rtc_present 1. No clearing pass.
// Depends on gpsr_pkg, gpsr_rtc and gpio_port_serial_rtc_top_macros.svh.
`include "gpio_port_serial_rtc_top_macros.svh"
module gpio_port_serial_rtc_top
    import gpsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      in_vld_reg, in_vld_next;
    in_item_t  in_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_reg;

    logic       bug_compat_reg, rtc_present_reg;
    logic [3:0] latch_reg, latch_next;
    logic [3:0] pins_reg, pins_next;
    logic [3:0] dir_reg, dir_next;
    logic       rden_reg, rden_next;

    logic       advance, go, step, cfg_wr;
    logic [3:0] pins_gpio, rtc_pins;

    assign advance = !out_vld_reg || m_ready;
    assign go      = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_BUG_COMPAT:  prdata = {31'd0, bug_compat_reg};
            REG_RTC_PRESENT: prdata = {31'd0, rtc_present_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb begin
        latch_next = latch_reg;
        dir_next   = dir_reg;
        rden_next  = rden_reg;
        pins_gpio  = pins_reg;
        step       = 1'b0;
        case (in_reg.kind)
            KIND_DATA: begin
                latch_next = in_reg.value;
                pins_gpio  = bug_compat_reg ? in_reg.value
                                            : (pins_reg & ~dir_reg) | (in_reg.value & dir_reg);
                step       = rtc_present_reg;
            end
            KIND_DIR: begin
                dir_next = in_reg.value;
                if (!bug_compat_reg) begin
                    pins_gpio = (pins_reg & ~in_reg.value) | (latch_reg & in_reg.value);
                    step      = rtc_present_reg;
                end
            end
            KIND_CTRL: begin
                rden_next = in_reg.value[0];
            end
            default: begin
            end
        endcase
        pins_next = step ? rtc_pins : pins_gpio;
    end

    gpsr_rtc u_rtc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (go && step),
        .pins_in   (pins_gpio),
        .dir_mask  (dir_next),
        .clock_bcd (in_reg.clock_bcd),
        .pins_out  (rtc_pins)
    );

    always_comb begin
        in_vld_next  = s_ready ? s_valid : in_vld_reg;
        out_vld_next = go ? 1'b1 : (out_vld_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            bug_compat_reg  <= 1'b0;
            rtc_present_reg <= 1'b1;
            latch_reg       <= 4'd0;
            pins_reg        <= 4'd0;
            dir_reg         <= 4'd0;
            rden_reg        <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_BUG_COMPAT:  bug_compat_reg  <= pwdata[0];
                    REG_RTC_PRESENT: rtc_present_reg <= pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (go) begin
                latch_reg <= latch_next;
                pins_reg  <= pins_next;
                dir_reg   <= dir_next;
                rden_reg  <= rden_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (go) begin
            out_reg.visible_data      <= rden_next ? pins_next : 4'd0;
            out_reg.visible_direction <= rden_next ? dir_next : 4'd0;
            out_reg.visible_control   <= rden_next;
            out_reg.pins_now          <= pins_next;
        end
    end

    `GPSR_ASSERT_IMP(a_hidden_zero,
        out_vld_reg && !out_reg.visible_control,
        out_reg.visible_data == 4'd0 && out_reg.visible_direction == 4'd0)
    `GPSR_ASSERT_IMP(a_visible_pins,
        out_vld_reg && out_reg.visible_control,
        out_reg.visible_data == out_reg.pins_now)
    `GPSR_ASSERT_NXT(a_pipe_moves, in_vld_reg && !out_vld_reg, out_vld_reg)

endmodule
